FILE: rtl/core/b64d_pkg.sv
// Shared types, constants and the character decode function of the base64 decoder.
`default_nettype none

package b64d_pkg;

    localparam logic [7:0] CHAR_PAD    = 8'h3D;  // '='
    localparam logic [7:0] CHAR_PLUS   = 8'h2B;  // '+'
    localparam logic [7:0] CHAR_SLASH  = 8'h2F;  // '/'
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;

    localparam logic [5:0] SEXTET_LOWER_BASE = 6'd26;
    localparam logic [5:0] SEXTET_DIGIT_BASE = 6'd52;
    localparam logic [5:0] SEXTET_PLUS       = 6'd62;
    localparam logic [5:0] SEXTET_SLASH      = 6'd63;

    typedef struct packed {
        logic       kept;   // a symbol or the pad character
        logic       pad;
        logic [5:0] value;  // zero for the pad character
    } char_info_t;

    // Up to three decoded bytes and an optional end-of-message result.
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      nbytes;
        logic            endm;
        logic            bad;
    } bundle_t;

    function automatic char_info_t decode_char(input logic [7:0] ch);
        char_info_t info;
        logic [7:0] offs;
        info = '0;
        offs = '0;
        case (ch) inside
            [CHAR_UPPER_A:CHAR_UPPER_Z]:
            begin
                offs = ch - CHAR_UPPER_A;
                info.kept = 1'b1;
                info.value = offs[5:0];
            end
            [CHAR_LOWER_A:CHAR_LOWER_Z]:
            begin
                offs = ch - CHAR_LOWER_A;
                info.kept = 1'b1;
                info.value = offs[5:0] + SEXTET_LOWER_BASE;
            end
            [CHAR_DIGIT_0:CHAR_DIGIT_9]:
            begin
                offs = ch - CHAR_DIGIT_0;
                info.kept = 1'b1;
                info.value = offs[5:0] + SEXTET_DIGIT_BASE;
            end
            CHAR_PLUS:
            begin
                info.kept = 1'b1;
                info.value = SEXTET_PLUS;
            end
            CHAR_SLASH:
            begin
                info.kept = 1'b1;
                info.value = SEXTET_SLASH;
            end
            CHAR_PAD:
            begin
                info.kept = 1'b1;
                info.pad = 1'b1;
            end
            default:
            begin
                info = '0;
            end
        endcase
        return info;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/b64d_group.sv
// Group assembly: holds the partial group and builds the results of one character.
`default_nettype none

module b64d_group (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [7:0]       char_in,
    input  wire logic             end_of_text,
    input  wire logic             bun_ready,
    output logic                  bun_valid,
    output b64d_pkg::bundle_t     bun
);

    logic [1:0]      fill_reg, fill_next;
    logic [2:0][5:0] sext_reg, sext_next;
    logic [2:0]      pad_reg, pad_next;
    logic            err_reg, err_next;

    b64d_pkg::char_info_t info;
    logic                 accept;
    logic                 err_grp;

    assign in_stall = !bun_ready;
    assign accept   = in_valid && bun_ready;
    assign info     = b64d_pkg::decode_char(char_in);

    always_comb
    begin
        fill_next = fill_reg;
        sext_next = sext_reg;
        pad_next  = pad_reg;
        err_grp   = err_reg;
        bun       = '0;

        bun.bytes[0] = {sext_reg[0], sext_reg[1][5:4]};
        bun.bytes[1] = {sext_reg[1][3:0], sext_reg[2][5:2]};
        bun.bytes[2] = {sext_reg[2][1:0], info.value};

        if (info.kept)
        begin
            if (fill_reg != 2'd3)
            begin
                sext_next[fill_reg] = info.value;
                pad_next[fill_reg]  = info.pad;
                fill_next           = fill_reg + 2'd1;
            end
            else
            begin
                // The fourth character completes the group.
                err_grp = err_reg | pad_reg[0] | pad_reg[1];
                if (!err_grp)
                begin
                    if (pad_reg[2])
                        bun.nbytes = 2'd1;
                    else if (info.pad)
                        bun.nbytes = 2'd2;
                    else
                        bun.nbytes = 2'd3;
                end
                fill_next = '0;
                sext_next = '0;
                pad_next  = '0;
            end
        end

        err_next = err_grp;
        if (end_of_text)
        begin
            bun.endm  = 1'b1;
            bun.bad   = err_grp;
            fill_next = '0;
            sext_next = '0;
            pad_next  = '0;
            err_next  = 1'b0;
        end
    end

    assign bun_valid = accept && (bun.endm || (bun.nbytes != 2'd0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            sext_reg <= '0;
            pad_reg  <= '0;
            err_reg  <= 1'b0;
        end
        else if (accept)
        begin
            fill_reg <= fill_next;
            sext_reg <= sext_next;
            pad_reg  <= pad_next;
            err_reg  <= err_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/b64d_emit.sv
// Result buffer, output register: sends a character's results one per unstalled cycle.
`default_nettype none

module b64d_emit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              bun_valid,
    input  wire b64d_pkg::bundle_t bun,
    output logic                   bun_ready,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [7:0]             out_byte,
    output logic                   end_mark,
    output logic                   bad_input,
    output logic                   last
);

    b64d_pkg::bundle_t bnd_reg;
    logic              bnd_valid_reg;
    logic [1:0]        idx_reg;

    logic              out_valid_reg;
    logic [7:0]        byte_reg;
    logic              endm_reg;
    logic              bad_reg;
    logic              last_reg;

    logic [2:0]        total;
    logic [2:0]        idx_plus;
    logic              cur_final;
    logic              cur_end;
    logic [7:0]        cur_byte;
    logic              out_load;

    assign total     = {1'b0, bnd_reg.nbytes} + {2'b00, bnd_reg.endm};
    assign idx_plus  = {1'b0, idx_reg} + 3'd1;
    assign cur_final = (idx_plus == total);
    assign cur_end   = (idx_reg == bnd_reg.nbytes);

    always_comb
    begin
        case (idx_reg)
            2'd0:    cur_byte = bnd_reg.bytes[0];
            2'd1:    cur_byte = bnd_reg.bytes[1];
            2'd2:    cur_byte = bnd_reg.bytes[2];
            default: cur_byte = '0;
        endcase
        if (cur_end)
            cur_byte = '0;
    end

    assign out_load  = bnd_valid_reg && (!out_valid_reg || !out_stall);
    // A new bundle may enter in the cycle the last result of the old one leaves.
    assign bun_ready = !bnd_valid_reg || (out_load && cur_final);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bnd_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else if (bun_valid)
        begin
            bnd_valid_reg <= 1'b1;
            idx_reg       <= '0;
        end
        else if (out_load)
        begin
            if (cur_final)
                bnd_valid_reg <= 1'b0;
            else
                idx_reg <= idx_plus[1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (bun_valid)
            bnd_reg <= bun;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            byte_reg <= cur_byte;
            endm_reg <= cur_end;
            bad_reg  <= cur_end && bnd_reg.bad;
            last_reg <= cur_final;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = byte_reg;
    assign end_mark  = endm_reg;
    assign bad_input = bad_reg;
    assign last      = last_reg;

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        bnd_valid_reg |-> ({1'b0, idx_reg} < total))
        else $error("result index beyond the buffered results");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && endm_reg) |-> (last_reg && (byte_reg == 8'd0)))
        else $error("end result is not the final, zero-byte result");

    a_bad_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && bad_reg) |-> endm_reg)
        else $error("error status on a byte result");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        bun_valid |-> (!bnd_valid_reg || (out_load && cur_final)))
        else $error("bundle overwritten before all its results left");

endmodule

`default_nettype wire

FILE: rtl/core/base64_stream_decoder.sv
// Top level of the streaming base64 decoder.
`default_nettype none

// Takes one text character per transfer and returns decoded bytes and, at the
// end of each message, one end result with the error status. A character that
// causes no result, or only one, is taken every cycle while the output is not
// stalled. A character that causes n results (a completed group gives one to
// three bytes, the end of a message adds one) holds the result buffer until all
// have left, since the output register sends one result per cycle; the next
// character is taken in the cycle that the last of them moves to the output
// register. Results pass through the result buffer, then the output register.
module base64_stream_decoder (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] char_in,
    input  wire logic       end_of_text,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic            end_mark,
    output logic            bad_input,
    output logic            last
);

    logic              bun_ready;
    logic              bun_valid;
    b64d_pkg::bundle_t bun;

    b64d_group u_group (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .char_in     (char_in),
        .end_of_text (end_of_text),
        .bun_ready   (bun_ready),
        .bun_valid   (bun_valid),
        .bun         (bun)
    );

    b64d_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .bun_valid (bun_valid),
        .bun       (bun),
        .bun_ready (bun_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .end_mark  (end_mark),
        .bad_input (bad_input),
        .last      (last)
    );

endmodule

`default_nettype wire
